### src/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_SIGNED  = 4'd1,
        PH_ZERO    = 4'd2,
        PH_PREFIX  = 4'd3,
        PH_DIGITS  = 4'd4,
        PH_STOPPED = 4'd5,
        PH_DATA    = 4'd6,
        PH_TRAIL1  = 4'd7,
        PH_TRAIL2  = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

### src/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes a chunked HTTP body byte stream into its payload bytes.
// ----------------------------------------------------------------------------
// channel   dir   tdata             tuser      tlast
// s_*       in    in_byte [7:0]     -          in_last
// m_*       out   out_byte [7:0]    has_data   body_end
//
// one byte per clock unless m_tready stalls; each request is decoded in the
// cycle it is accepted and its result is then held in the output register.
// the output register is the only stage: s_tready is high while it is empty
// or being drained, so a stall on m_tready holds the input side too.
// aresetn (synchronous, active low) returns the parser to the start of a
// size line and empties the output register.
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = 31
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] has_data
    output logic       m_tlast
);

    typedef struct packed {
        hcbd_pkg::phase_t      phase;
        logic [SIZE_BITS-1:0]  accum;
        logic                  neg;
    } line_t;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    line_t                st_reg, st_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 pend_reg, pend_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       s_accept;
    logic       in_line;
    logic       has_data;
    logic       body_end;
    logic [7:0] out_byte;

    function automatic logic [SIZE_BITS-1:0] add_digit(input logic [SIZE_BITS-1:0] a,
                                                       input logic [3:0] d);
        // saturates once any of the top four bits would be shifted out
        if (|a[SIZE_BITS-1 -: 4]) begin
            return SIZE_MAX;
        end
        return {a[SIZE_BITS-5:0], d};
    endfunction

    function automatic line_t feed(input line_t st, input logic [7:0] c);
        line_t          r;
        hcbd_pkg::hex_t h;
        hcbd_pkg::phase_t ph;
        r  = st;
        h  = hcbd_pkg::hex_decode(c);
        ph = st.phase;
        if (ph == hcbd_pkg::PH_LEAD) begin
            if (hcbd_pkg::is_space(c)) begin
                return r;
            end else if (c == hcbd_pkg::CHAR_PLUS || c == hcbd_pkg::CHAR_MINUS) begin
                r.neg   = (c == hcbd_pkg::CHAR_MINUS);
                r.phase = hcbd_pkg::PH_SIGNED;
                return r;
            end
            ph = hcbd_pkg::PH_SIGNED;
        end
        case (ph)
            hcbd_pkg::PH_SIGNED: begin
                if (h.valid && h.value == 4'd0) begin
                    r.phase = hcbd_pkg::PH_ZERO;
                end else if (h.valid) begin
                    r.accum = add_digit(st.accum, h.value);
                    r.phase = hcbd_pkg::PH_DIGITS;
                end else begin
                    r.phase = hcbd_pkg::PH_STOPPED;
                end
            end
            hcbd_pkg::PH_ZERO: begin
                if (c == hcbd_pkg::CHAR_LX || c == hcbd_pkg::CHAR_UX) begin
                    r.phase = hcbd_pkg::PH_PREFIX;
                end else if (h.valid) begin
                    r.accum = add_digit(st.accum, h.value);
                    r.phase = hcbd_pkg::PH_DIGITS;
                end else begin
                    r.phase = hcbd_pkg::PH_STOPPED;
                end
            end
            hcbd_pkg::PH_PREFIX, hcbd_pkg::PH_DIGITS: begin
                if (h.valid) begin
                    r.accum = add_digit(st.accum, h.value);
                    r.phase = hcbd_pkg::PH_DIGITS;
                end else begin
                    r.phase = hcbd_pkg::PH_STOPPED;
                end
            end
            default: begin
                r.phase = st.phase;
            end
        endcase
        return r;
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign in_line  = st_reg.phase inside {hcbd_pkg::PH_LEAD, hcbd_pkg::PH_SIGNED,
                                           hcbd_pkg::PH_ZERO, hcbd_pkg::PH_PREFIX,
                                           hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_STOPPED};

    // next state
    always_comb begin
        line_t st_cr;
        st_next   = st_reg;
        left_next = left_reg;
        pend_next = pend_reg;
        st_cr     = st_reg;
        if (s_accept) begin
            if (in_line) begin
                if (pend_reg) begin
                    pend_next = 1'b0;
                    if (s_tdata == hcbd_pkg::CHAR_LF) begin
                        if (st_reg.neg || st_reg.accum == '0) begin
                            st_next.phase = hcbd_pkg::PH_DONE;
                        end else begin
                            left_next     = st_reg.accum;
                            st_next.phase = hcbd_pkg::PH_DATA;
                        end
                        st_next.accum = '0;
                        st_next.neg   = 1'b0;
                    end else begin
                        // the held CR joins the line: blank while leading, else a stop
                        if (st_reg.phase != hcbd_pkg::PH_LEAD) begin
                            st_cr.phase = hcbd_pkg::PH_STOPPED;
                        end
                        st_next = st_cr;
                        if (s_tdata == hcbd_pkg::CHAR_CR) begin
                            pend_next = 1'b1;
                        end else begin
                            st_next = feed(st_cr, s_tdata);
                        end
                    end
                end else if (s_tdata == hcbd_pkg::CHAR_CR) begin
                    pend_next = 1'b1;
                end else begin
                    st_next = feed(st_reg, s_tdata);
                end
            end else begin
                case (st_reg.phase)
                    hcbd_pkg::PH_DATA: begin
                        left_next = left_reg - SIZE_BITS'(left_reg != '0);
                        if (left_next == '0) begin
                            st_next.phase = hcbd_pkg::PH_TRAIL1;
                        end
                    end
                    hcbd_pkg::PH_TRAIL1: begin
                        st_next.phase = hcbd_pkg::PH_TRAIL2;
                    end
                    hcbd_pkg::PH_TRAIL2: begin
                        st_next.phase = hcbd_pkg::PH_LEAD;
                        st_next.accum = '0;
                        st_next.neg   = 1'b0;
                        pend_next     = 1'b0;
                    end
                    default: begin
                        st_next.phase = st_reg.phase;
                    end
                endcase
            end
            if (s_tlast) begin
                st_next.phase = hcbd_pkg::PH_LEAD;
                st_next.accum = '0;
                st_next.neg   = 1'b0;
                pend_next     = 1'b0;
                left_next     = '0;
            end
        end
    end

    // outputs for the request at the input
    always_comb begin
        has_data = (st_reg.phase == hcbd_pkg::PH_DATA);
        out_byte = has_data ? s_tdata : 8'h00;
        body_end = (in_line && pend_reg && s_tdata == hcbd_pkg::CHAR_LF &&
                    (st_reg.neg || st_reg.accum == '0)) ||
                   (s_tlast && st_reg.phase != hcbd_pkg::PH_DONE);
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (s_accept) begin
            m_tvalid_next = has_data || body_end;
            m_tdata_next  = out_byte;
            m_tuser_next  = has_data;
            m_tlast_next  = body_end;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase <= hcbd_pkg::PH_LEAD;
            st_reg.accum <= '0;
            st_reg.neg   <= 1'b0;
            left_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            left_reg     <= left_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
